@@ rtl/iff_pkg.sv @@
//------------------------------------------------------------------------------
// iff_pkg: shared types and constants for the integer field formatter
// Conversion codes, state encoding and default sizes.
//------------------------------------------------------------------------------
package iff_pkg;

    localparam int unsigned DEF_VALUE_BITS = 64;
    localparam int unsigned DEF_MAX_FIELD  = 63;

    typedef enum logic [2:0] {
        CMD_SDEC = 3'd0,
        CMD_UDEC = 3'd1,
        CMD_OCT  = 3'd2,
        CMD_HEXL = 3'd3,
        CMD_HEXU = 3'd4,
        CMD_PTR  = 3'd5
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_PLAN,
        ST_EMIT
    } t_state;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;

    // Map a 4-bit digit to ASCII.
    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] r;
        begin
            if (d < 4'd10) begin
                r = CH_ZERO + {4'd0, d};
            end else if (upper) begin
                r = 8'h37 + {4'd0, d};
            end else begin
                r = 8'h57 + {4'd0, d};
            end
            return r;
        end
    endfunction

endpackage

@@ rtl/integer_field_formatter.sv @@
//------------------------------------------------------------------------------
// integer_field_formatter: printf-style integer field formatter
// Turns one value plus parsed conversion and flags into ASCII characters.
//------------------------------------------------------------------------------
// One item is worked on at a time. Decimal digits come out of a bit-serial
// shift-and-add-3 converter, one value bit per cycle, which then hands
// over its stored digits one at a time; octal and hex digits are taken
// straight from the value. Digits go into a small RAM least significant
// first. A planning state follows, then the field leaves through a single
// output register while the output side takes it: pad, sign, prefix and
// zero-fill characters go straight into the output register, and each digit
// is first read from the RAM, then loaded into the output register. A field
// that comes out empty (zero with zero precision, no width and no sign,
// prefix or alternate-form zero) produces no item at all.
module integer_field_formatter
    import iff_pkg::*;
#(
    parameter int unsigned VALUE_BITS = DEF_VALUE_BITS,
    parameter int unsigned MAX_FIELD  = DEF_MAX_FIELD
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata, low bit up: cmd[2:0], value[66:3], field_width[72:67],
    // digit_precision[78:73], precision_given[79], left_justify[80],
    // zero_pad[81], force_sign[82], space_sign[83], alternate_form[84], pad
    input  logic [87:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: ch[7:0]
    output logic [7:0]  m_tdata,
    output logic        m_tlast
);
    localparam int unsigned ND      = (VALUE_BITS * 3 + 9) / 10 + 1; // decimal digits
    localparam int unsigned DEPTH   = 32;
    localparam int unsigned AW      = 5;
    localparam int unsigned CW      = 7;   // counts up to 127
    localparam int unsigned BCW     = $clog2(VALUE_BITS + 1);

    t_state r_state, n_state;

    // captured item
    logic [VALUE_BITS-1:0] r_val, n_val;
    logic [2:0]  r_cmd, n_cmd;
    logic [CW-1:0] r_width, n_width, r_prec, n_prec;
    logic r_left, n_left, r_zpad, n_zpad, r_alt, n_alt;
    logic [7:0]  r_pre0, n_pre0, r_pre1, n_pre1;
    logic [1:0]  r_plen, n_plen;

    // BCD shift register, one nibble per digit
    logic [ND*4-1:0] r_bcd, n_bcd;
    logic [BCW-1:0]  r_bcnt, n_bcnt;
    logic [AW:0]     r_nd, n_nd;   // digits stored

    // emission plan
    logic [CW-1:0] r_pad, n_pad, r_zeros, n_zeros, r_pos, n_pos, r_len, n_len;
    logic [AW:0]   r_didx, n_didx;

    // output register
    logic       r_ovld, n_ovld;
    logic [7:0] r_och, n_och;
    logic       r_olast, n_olast;

    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [3:0]    w_wdata, w_rdata;
    logic          r_rd_pend, n_rd_pend;

    iff_digit_ram #(.WIDTH(4), .DEPTH(DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign s_tready = (r_state == ST_IDLE) && !r_ovld;
    assign m_tvalid = r_ovld;
    assign m_tdata  = r_och;
    assign m_tlast  = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_ovld    <= 1'b0;
            r_rd_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ovld    <= n_ovld;
            r_rd_pend <= n_rd_pend;
        end
        r_val <= n_val;   r_cmd <= n_cmd;   r_width <= n_width; r_prec <= n_prec;
        r_left <= n_left; r_zpad <= n_zpad; r_alt <= n_alt;
        r_pre0 <= n_pre0; r_pre1 <= n_pre1; r_plen <= n_plen;
        r_bcd <= n_bcd;   r_bcnt <= n_bcnt; r_nd <= n_nd;
        r_pad <= n_pad;   r_zeros <= n_zeros; r_pos <= n_pos; r_len <= n_len;
        r_didx <= n_didx; r_och <= n_och;   r_olast <= n_olast;
    end

    // next-state and datapath
    always_comb begin
        logic [2:0]            c;
        logic [VALUE_BITS-1:0] v;
        logic [5:0]            fw, fp;
        logic                  pg, neg;
        logic [ND*4-1:0]       adj;
        logic [3:0]            nib;
        logic [CW-1:0]         cnt, tot, ndw;
        logic                  emit;
        logic [7:0]            ch;
        logic [CW-1:0]         k;

        n_state = r_state; n_val = r_val; n_cmd = r_cmd; n_width = r_width;
        n_prec = r_prec; n_left = r_left; n_zpad = r_zpad; n_alt = r_alt;
        n_pre0 = r_pre0; n_pre1 = r_pre1; n_plen = r_plen;
        n_bcd = r_bcd; n_bcnt = r_bcnt; n_nd = r_nd; n_pad = r_pad;
        n_zeros = r_zeros; n_pos = r_pos; n_len = r_len; n_didx = r_didx;
        n_ovld = r_ovld; n_och = r_och; n_olast = r_olast; n_rd_pend = 1'b0;
        w_we = 1'b0; w_waddr = r_nd[AW-1:0]; w_wdata = 4'd0;
        w_raddr = r_didx[AW-1:0] - AW'(1);
        c = 3'd0; v = '0; fw = '0; fp = '0; pg = 1'b0; neg = 1'b0; adj = '0;
        nib = '0; cnt = '0; tot = '0; ndw = '0; emit = 1'b0; ch = '0; k = '0;

        if (r_ovld && m_tready) begin
            n_ovld = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    c  = s_tdata[2:0];
                    if (c > 3'd5) c = CMD_UDEC;
                    v  = s_tdata[3 +: VALUE_BITS];
                    fw = s_tdata[72:67];
                    fp = s_tdata[78:73];
                    pg = s_tdata[79];
                    n_cmd = c;
                    n_width = (CW'(fw) > CW'(MAX_FIELD)) ? CW'(MAX_FIELD) : CW'(fw);
                    n_prec = !pg ? CW'(1) :
                        ((CW'(fp) > CW'(MAX_FIELD - 3)) ? CW'(MAX_FIELD - 3) : CW'(fp));
                    n_left = s_tdata[80];
                    n_zpad = s_tdata[81] && !pg;
                    n_alt  = s_tdata[84];
                    n_plen = 2'd0;
                    neg = (c == CMD_SDEC) && v[VALUE_BITS-1];
                    if (neg) v = ~v + VALUE_BITS'(1);
                    if (c == CMD_SDEC) begin
                        if (neg) begin
                            n_pre0 = CH_MINUS; n_plen = 2'd1;
                        end else if (s_tdata[82]) begin
                            n_pre0 = CH_PLUS;  n_plen = 2'd1;
                        end else if (s_tdata[83]) begin
                            n_pre0 = CH_SPACE; n_plen = 2'd1;
                        end
                    end else if (c == CMD_PTR ||
                                 ((c == CMD_HEXL || c == CMD_HEXU) && s_tdata[84] && v != '0)) begin
                        n_pre0 = CH_ZERO;
                        n_pre1 = (c == CMD_HEXU) ? 8'h58 : 8'h78;
                        n_plen = 2'd2;
                    end
                    n_val = v;
                    n_bcd = '0;
                    n_bcnt = '0;
                    n_nd = '0;
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                if (r_cmd == CMD_SDEC || r_cmd == CMD_UDEC) begin
                    if (r_bcnt != BCW'(VALUE_BITS)) begin
                        // shift one value bit into the BCD register
                        for (int i = 0; i < ND; i++) begin
                            nib = r_bcd[i*4 +: 4];
                            adj[i*4 +: 4] = (nib > 4'd4) ? nib + 4'd3 : nib;
                        end
                        n_bcd = {adj[ND*4-2:0], r_val[VALUE_BITS-1]};
                        n_val = {r_val[VALUE_BITS-2:0], 1'b0};
                        n_bcnt = r_bcnt + BCW'(1);
                    end else if (r_bcd != '0) begin
                        w_we = 1'b1; w_wdata = r_bcd[3:0];
                        n_bcd = r_bcd >> 4;
                        n_nd = r_nd + (AW+1)'(1);
                    end else begin
                        n_state = ST_PLAN;
                    end
                end else begin
                    if (r_val != '0) begin
                        w_we = 1'b1;
                        if (r_cmd == CMD_OCT) begin
                            w_wdata = {1'b0, r_val[2:0]};
                            n_val = r_val >> 3;
                        end else begin
                            w_wdata = r_val[3:0];
                            n_val = r_val >> 4;
                        end
                        n_nd = r_nd + (AW+1)'(1);
                    end else begin
                        n_state = ST_PLAN;
                    end
                end
            end
            ST_PLAN: begin
                ndw = CW'(r_nd);
                cnt = (ndw > r_prec) ? ndw : r_prec;
                if (r_cmd == CMD_OCT && r_alt && cnt == ndw) cnt = ndw + CW'(1);
                tot = CW'(r_plen) + cnt;
                n_pad = (r_width > tot) ? r_width - tot : '0;
                n_zeros = cnt - ndw;
                n_len = (r_width > tot) ? r_width : tot;
                n_pos = '0;
                n_didx = r_nd;
                n_state = (n_len == '0) ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT: begin
                // walk the field: pad, prefix, zero fill, digits, right pad
                if (!n_ovld && !r_rd_pend) begin
                    k = r_pos;
                    emit = 1'b1;
                    if (!r_left && !r_zpad && k < r_pad) begin
                        ch = CH_SPACE;
                    end else begin
                        if (!r_left && !r_zpad) k = k - r_pad;
                        if (k < CW'(r_plen)) begin
                            ch = (k == '0) ? r_pre0 : r_pre1;
                        end else begin
                            k = k - CW'(r_plen);
                            if (r_zpad && !r_left) begin
                                if (k < r_pad) begin
                                    ch = CH_ZERO;
                                end else begin
                                    k = k - r_pad;
                                end
                            end
                            if (!(r_zpad && !r_left && r_pos - CW'(r_plen) < r_pad)) begin
                                if (k < r_zeros) begin
                                    ch = CH_ZERO;
                                end else if (r_didx != '0) begin
                                    // fetch digit, load it into the output register next cycle
                                    emit = 1'b0;
                                    n_rd_pend = 1'b1;
                                end else begin
                                    ch = CH_SPACE;
                                end
                            end
                        end
                    end
                    if (emit) begin
                        n_ovld = 1'b1; n_och = ch;
                        n_olast = (r_pos + CW'(1) == r_len);
                        n_pos = r_pos + CW'(1);
                        if (n_olast) n_state = ST_IDLE;
                    end
                end else if (!n_ovld && r_rd_pend) begin
                    n_ovld = 1'b1;
                    n_och = digit_char(w_rdata, r_cmd == CMD_HEXU);
                    n_olast = (r_pos + CW'(1) == r_len);
                    n_pos = r_pos + CW'(1);
                    n_didx = r_didx - (AW+1)'(1);
                    if (n_olast) n_state = ST_IDLE;
                end else if (r_rd_pend) begin
                    n_rd_pend = 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tready |-> r_state == ST_IDLE) else $error("accept while busy");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tready && m_tlast) |-> !(r_state == ST_EMIT))
        else $error("last item without return to idle");
    a_digits_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CONV) |-> r_nd <= (AW+1)'(DEPTH)) else $error("digit store overflow");
`endif
endmodule

@@ rtl/iff_digit_ram.sv @@
//------------------------------------------------------------------------------
// iff_digit_ram: generic simple dual-port RAM with registered read
// One write port and one read port, read data valid the cycle after.
//------------------------------------------------------------------------------
module iff_digit_ram #(
    parameter int unsigned WIDTH = 4,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ sim/iff_field_checker.sv @@
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// iff_field_checker: output checker for the integer field formatter
// Watches both stream channels, builds the expected character string of
// every accepted input item and compares each emitted character with it.
//------------------------------------------------------------------------------
module iff_field_checker
    import iff_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [87:0] i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  i_m_tdata,
    input  logic        i_m_tlast,
    output int          o_fail_count,
    output int          o_chars_pending
);

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_char;

    t_char expected_chars[$];

    // Build the formatted field for one input item and queue its characters.
    task automatic queue_field(input logic [87:0] word);
        logic [2:0]  conv;
        logic [63:0] v;
        logic [5:0]  width;
        int          prec, nd, count, plen, total, pad, i;
        logic        pgiven, left, zpad, plus, blank, alt, nonzero;
        logic [7:0]  pre[2];
        logic [7:0]  dig[64];
        logic [7:0]  line[$];
        t_char       c;
        conv   = word[2:0];
        v      = word[66:3];
        width  = word[72:67];
        pgiven = word[79];
        prec   = pgiven ? ((word[78:73] > 60) ? 60 : int'(word[78:73])) : 1;
        left   = word[80];
        zpad   = word[81];
        plus   = word[82];
        blank  = word[83];
        alt    = word[84];
        plen   = 0;
        nd     = 0;
        if (conv > CMD_PTR) conv = CMD_UDEC;
        if (conv == CMD_SDEC) begin
            if (v[63]) begin
                v = -v;
                pre[0] = CH_MINUS;
                plen = 1;
            end else if (plus) begin
                pre[0] = CH_PLUS;
                plen = 1;
            end else if (blank) begin
                pre[0] = CH_SPACE;
                plen = 1;
            end
        end
        nonzero = (v != 0);
        if (conv <= CMD_UDEC) begin
            while (v != 0) begin
                dig[nd++] = 8'h30 + 8'(v % 10);
                v = v / 10;
            end
        end else if (conv == CMD_OCT) begin
            while (v != 0) begin
                dig[nd++] = 8'h30 + 8'(v[2:0]);
                v = v >> 3;
            end
        end else begin
            while (v != 0) begin
                if (v[3:0] < 10) dig[nd] = 8'h30 + 8'(v[3:0]);
                else if (conv == CMD_HEXU) dig[nd] = 8'h37 + 8'(v[3:0]);
                else dig[nd] = 8'h57 + 8'(v[3:0]);
                nd++;
                v = v >> 4;
            end
            if (conv == CMD_PTR || (alt && nonzero)) begin
                pre[0] = "0";
                pre[1] = (conv == CMD_HEXU) ? "X" : "x";
                plen = 2;
            end
        end
        count = (nd > prec) ? nd : prec;
        if (conv == CMD_OCT && alt && count == nd) count = nd + 1;
        total = plen + count;
        pad   = (width > total) ? int'(width) - total : 0;
        if (!left && !(zpad && !pgiven)) for (i = 0; i < pad; i++) line.push_back(CH_SPACE);
        for (i = 0; i < plen; i++) line.push_back(pre[i]);
        if (!left && zpad && !pgiven) for (i = 0; i < pad; i++) line.push_back(CH_ZERO);
        for (i = nd; i < count; i++) line.push_back(CH_ZERO);
        for (i = nd; i > 0; i--) line.push_back(dig[i-1]);
        if (left) for (i = 0; i < pad; i++) line.push_back(CH_SPACE);
        for (i = 0; i < line.size(); i++) begin
            c.ch   = line[i];
            c.last = (i == line.size() - 1);
            expected_chars.push_back(c);
        end
    endtask

    always @(posedge i_clk) begin
        t_char want;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (expected_chars.size() == 0) begin
                    $display("%0t: unexpected char expected none actual %h last %b",
                             $time, i_m_tdata, i_m_tlast);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_chars.pop_front();
                    if (want.ch !== i_m_tdata || want.last !== i_m_tlast) begin
                        $display("%0t: mismatch expected %h/%b actual %h/%b", $time,
                                 want.ch, want.last, i_m_tdata, i_m_tlast);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) queue_field(i_s_tdata);
        end
        o_chars_pending <= expected_chars.size();
    end

endmodule

@@ sim/tb_integer_field_formatter.sv @@
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// tb_integer_field_formatter: testbench for the integer field formatter
// Drives directed and random conversions with random stalls on both sides;
// a separate checker predicts every character and counts mismatches.
//------------------------------------------------------------------------------
module tb_integer_field_formatter;
    import iff_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;   // cmd, value, width, precision, flags (see dut)
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // ch
    logic        m_tlast;
    int          fail_count;
    int          chars_pending;
    int          idle_cycles;
    logic        calm;      // no idling while set

    integer_field_formatter dut (
        .i_clk, .i_rst_n, .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata, .m_tlast
    );

    iff_field_checker checker_i (
        .i_clk, .i_rst_n,
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .i_m_tlast(m_tlast),
        .o_fail_count(fail_count), .o_chars_pending(chars_pending)
    );

    always begin
        i_clk = 1'b0; #2;
        i_clk = 1'b1; #2;
    end

    // Stall the output side about 16 times in 100, except in calm stretches.
    always @(posedge i_clk) begin
        m_tready <= calm || ($urandom_range(99) >= 16);
    end

    // Count cycles in which neither channel moves an item.
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("tb_integer_field_formatter failed");
            $finish;
        end
    end

    function automatic logic [87:0] pack_item(
        input logic [2:0] cmd, input logic [63:0] value, input logic [5:0] width,
        input logic [5:0] prec, input logic [5:0] flags);
        // flags low bit up: pgiven, left, zpad, plus, blank, alt
        return {3'b0, flags, prec, width, value, cmd};
    endfunction

    // Present one item, with an optional idle gap first, and hold until taken.
    task automatic send_item(input logic [87:0] word);
        while (!calm && $urandom_range(99) < 16) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    function automatic logic [63:0] random_value();
        case ($urandom_range(5))
            0: return 64'($urandom_range(20));
            1: return {$urandom, $urandom};
            2: return 64'h8000_0000_0000_0000 | 64'($urandom);
            3: return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(20));
            4: return 64'($urandom) >> $urandom_range(31);
            default: return {$urandom, $urandom} >> $urandom_range(63);
        endcase
    endfunction

    initial begin
        logic [5:0] width, prec;
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        calm     = 1'b0;
        idle_cycles = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, every conversion and the corner cases.
        send_item(pack_item(CMD_SDEC, 64'h8000_0000_0000_0000, 6'd0, 6'd0, 6'b000000));
        send_item(pack_item(CMD_SDEC, 64'h7FFF_FFFF_FFFF_FFFF, 6'd63, 6'd0, 6'b001100));
        send_item(pack_item(CMD_SDEC, 64'd42, 6'd10, 6'd0, 6'b010100));
        send_item(pack_item(CMD_SDEC, 64'hFFFF_FFFF_FFFF_FFFF, 6'd8, 6'd5, 6'b000011));
        send_item(pack_item(CMD_UDEC, 64'hFFFF_FFFF_FFFF_FFFF, 6'd0, 6'd0, 6'b111100));
        send_item(pack_item(CMD_UDEC, 64'd0, 6'd0, 6'd0, 6'b000001));  // empty field
        send_item(pack_item(CMD_UDEC, 64'd0, 6'd5, 6'd0, 6'b000001));
        send_item(pack_item(CMD_OCT, 64'd0, 6'd0, 6'd0, 6'b100001));
        send_item(pack_item(CMD_OCT, 64'o777, 6'd12, 6'd0, 6'b100100));
        send_item(pack_item(CMD_OCT, 64'o17, 6'd0, 6'd5, 6'b100001));
        send_item(pack_item(CMD_HEXL, 64'hDEAD_BEEF, 6'd16, 6'd0, 6'b100100));
        send_item(pack_item(CMD_HEXL, 64'd0, 6'd4, 6'd0, 6'b100000));
        send_item(pack_item(CMD_HEXU, 64'hFFFF_FFFF_FFFF_FFFF, 6'd63, 6'd63, 6'b100011));
        send_item(pack_item(CMD_PTR, 64'd0, 6'd0, 6'd0, 6'b111100));
        send_item(pack_item(CMD_PTR, 64'd0, 6'd0, 6'd0, 6'b000001));
        send_item(pack_item(CMD_PTR, 64'h1234, 6'd20, 6'd0, 6'b000100));
        send_item(pack_item(3'd6, 64'd123, 6'd0, 6'd0, 6'b011000));
        send_item(pack_item(3'd7, 64'd9, 6'd3, 6'd2, 6'b000001));

        // Random: with idling on both sides, except for a calm stretch in the middle.
        for (int n = 0; n < 92; n++) begin
            calm = (n >= 20 && n < 40);
            width = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(12));
            prec  = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(8));
            send_item(pack_item(3'($urandom), random_value(), width, prec, 6'($urandom)));
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        while (chars_pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_integer_field_formatter passed");
        end else begin
            $display("tb_integer_field_formatter failed");
        end
        $finish;
    end

endmodule
